FILE: sv/spherical_shell_exit_time_unit_macros.svh
// ---------------------------------------------------------------------------
// spherical shell exit time unit assertion macros
// shared concurrent assertion forms for the port checker
// ---------------------------------------------------------------------------
`ifndef SPHERICAL_SHELL_EXIT_TIME_UNIT_MACROS_SVH
`define SPHERICAL_SHELL_EXIT_TIME_UNIT_MACROS_SVH

// clocked assertion, off while in reset
`define SSET_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check that holds whenever a result item is shown
`define SSET_ON_RESULT(label, cond, msg) \
  `SSET_ASSERT(label, out_strobe_o |-> (cond), msg)

`endif

FILE: sv/sset_pkg.sv
// ---------------------------------------------------------------------------
// sset_pkg
// widths, boundary table and shared types of the shell exit time unit
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sset_pkg;

  localparam int unsigned COORD_W     = 31;
  localparam int unsigned MARGIN_W    = 10;
  localparam int unsigned MARGIN_SQ_W = 20;
  localparam int unsigned LAYER_W     = 5;
  localparam int unsigned LAYER_OUT_W = 4;
  localparam int unsigned TIME_W      = 48;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned PROD_W      = 62;
  localparam int unsigned SQ_W        = 62;
  localparam int unsigned DOT_W       = 64;
  localparam int unsigned RSQ_W       = 59;
  localparam int unsigned LIMB_W      = 31;
  localparam int unsigned MV_PROD_W   = 51;
  localparam int unsigned PP_W        = 124;
  localparam int unsigned QV_W        = 121;
  localparam int unsigned MV_W        = 82;
  localparam int unsigned RAD_W       = 126;
  localparam int unsigned ROOT_W      = 63;
  localparam int unsigned N_W         = 64;
  localparam int unsigned SCALE_W     = 30;
  localparam int unsigned NUM_W       = 94;
  localparam int unsigned DIV_W       = 110;

  localparam logic [SCALE_W-1:0] NS_PER_S = 30'd1000000000;

  // squared boundary radii in cm^2, tail repeats the outermost
  localparam logic [RSQ_W-1:0] RADIUS_SQ [16] = '{
    59'd14920622500000000,
    59'd121104000000000000,
    59'd325014010000000000,
    59'd333044410000000000,
    59'd356528410000000000,
    59'd378348010000000000,
    59'd402793315600000000,
    59'd403987360000000000,
    59'd405514240000000000,
    59'd405896410000000000,
    59'd405896410000000000,
    59'd405896410000000000,
    59'd405896410000000000,
    59'd405896410000000000,
    59'd405896410000000000,
    59'd405896410000000000
  };

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK         = 2'd0,
    STATUS_OUTSIDE    = 2'd1,
    STATUS_ZERO_SPEED = 2'd2
  } status_e;

  typedef struct packed {
    logic [LAYER_W-1:0] layer;
    status_e            status;
    logic               pneg;
    logic [SQ_W-1:0]    ap;
    logic [SQ_W-1:0]    v2;
  } item_t;

endpackage

`default_nettype wire

FILE: sv/sset_isqrt.sv
// ---------------------------------------------------------------------------
// sset_isqrt
// pipelined floor square root, one root bit per stage, side data in step
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sset_isqrt #(
  parameter int unsigned RAD_W  = 126,
  parameter int unsigned SIDE_W = 1,
  localparam int unsigned ROOT_W = RAD_W / 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [RAD_W-1:0]  radicand_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned REM_W = ROOT_W + 2;

  logic [ROOT_W-1:0] vld_q;
  logic [RAD_W-1:0]  rad_q  [ROOT_W];
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [SIDE_W-1:0] side_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              vld_c;
    logic [RAD_W-1:0]  rad_c;
    logic [REM_W-1:0]  rem_c;
    logic [ROOT_W-1:0] root_c;
    logic [SIDE_W-1:0] side_c;
    logic [REM_W-1:0]  shifted;
    logic [REM_W-1:0]  trial;
    logic              fits;

    if (k == 0) begin : g_first
      assign vld_c  = valid_i;
      assign rad_c  = radicand_i;
      assign rem_c  = '0;
      assign root_c = '0;
      assign side_c = side_i;
    end else begin : g_next
      assign vld_c  = vld_q[k-1];
      assign rad_c  = rad_q[k-1];
      assign rem_c  = rem_q[k-1];
      assign root_c = root_q[k-1];
      assign side_c = side_q[k-1];
    end

    assign shifted = {rem_c[REM_W-3:0], rad_c[RAD_W-1 -: 2]};
    assign trial   = {root_c, 2'b01};
    assign fits    = shifted >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_c;
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[k]  <= {rad_c[RAD_W-3:0], 2'b00};
      rem_q[k]  <= fits ? shifted - trial : shifted;
      root_q[k] <= {root_c[ROOT_W-2:0], fits};
      side_q[k] <= side_c;
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];

endmodule

`default_nettype wire

FILE: sv/spherical_shell_exit_time_unit.sv
// throughput: one item per cycle, start is taken in every cycle and busy stays low
// an item passes 7 front stages, the 63-stage root pipelines side by side, 5 stages,
// the 48-stage divider and the output register on its way to its result
// reset: asynchronous active low, clears all valid bits and sets the margin to 1 cm
// the receiver cannot stall, so no result is ever held back
// ---------------------------------------------------------------------------
// spherical_shell_exit_time_unit
// finds the layer holding a position and the time to leave it along the path
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spherical_shell_exit_time_unit #(
  parameter int BOUNDARY_COUNT = 10
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [sset_pkg::COORD_W-1:0]  pos_x_i,
  input  logic signed [sset_pkg::COORD_W-1:0]  pos_y_i,
  input  logic signed [sset_pkg::COORD_W-1:0]  pos_z_i,
  input  logic signed [sset_pkg::COORD_W-1:0]  vel_x_i,
  input  logic signed [sset_pkg::COORD_W-1:0]  vel_y_i,
  input  logic signed [sset_pkg::COORD_W-1:0]  vel_z_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [sset_pkg::MARGIN_W-1:0]        cfg_data_i,
  output logic                                 out_strobe_o,
  output logic [sset_pkg::LAYER_OUT_W-1:0]     layer_index_o,
  output logic [sset_pkg::TIME_W-1:0]          exit_time_ns_o,
  output logic                                 through_inner_o,
  output logic [sset_pkg::STATUS_W-1:0]        status_o
);

  localparam int unsigned PW = sset_pkg::PROD_W;
  localparam int unsigned SW = sset_pkg::SQ_W;
  localparam int unsigned LW = sset_pkg::LIMB_W;
  localparam int unsigned TW = sset_pkg::TIME_W;
  localparam int unsigned NW = sset_pkg::NUM_W;
  localparam int unsigned DW = sset_pkg::DIV_W;

  // margin register
  logic [sset_pkg::MARGIN_W-1:0] margin_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= 10'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      margin_q <= cfg_data_i;
    end
  end

  // valid chain of the front stages, stages 8 to 12 and the output register
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, s6_v_q, s7_v_q;
  logic s8_v_q, s9_v_q, s10_v_q, s11_v_q, s12_v_q, out_v_q;
  logic root_v, margin_v;
  logic [TW-1:0] dv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      s5_v_q  <= 1'b0;
      s6_v_q  <= 1'b0;
      s7_v_q  <= 1'b0;
      s8_v_q  <= 1'b0;
      s9_v_q  <= 1'b0;
      s10_v_q <= 1'b0;
      s11_v_q <= 1'b0;
      s12_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= start && !busy;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      s4_v_q  <= s3_v_q;
      s5_v_q  <= s4_v_q;
      s6_v_q  <= s5_v_q;
      s7_v_q  <= s6_v_q;
      s8_v_q  <= root_v && margin_v;
      s9_v_q  <= s8_v_q;
      s10_v_q <= s9_v_q;
      s11_v_q <= s10_v_q;
      s12_v_q <= s11_v_q;
      out_v_q <= dv_q[TW-1];
    end
  end

  // stage 1: component products
  logic signed [PW-1:0] xx_q, yy_q, zz_q, vvx_q, vvy_q, vvz_q, xv_q, yv_q, zv_q;

  always_ff @(posedge clk_i) begin
    xx_q  <= PW'(pos_x_i) * PW'(pos_x_i);
    yy_q  <= PW'(pos_y_i) * PW'(pos_y_i);
    zz_q  <= PW'(pos_z_i) * PW'(pos_z_i);
    vvx_q <= PW'(vel_x_i) * PW'(vel_x_i);
    vvy_q <= PW'(vel_y_i) * PW'(vel_y_i);
    vvz_q <= PW'(vel_z_i) * PW'(vel_z_i);
    xv_q  <= PW'(pos_x_i) * PW'(vel_x_i);
    yv_q  <= PW'(pos_y_i) * PW'(vel_y_i);
    zv_q  <= PW'(pos_z_i) * PW'(vel_z_i);
  end

  // stage 2: squared lengths and dot product
  logic [SW-1:0]                      x2_q, v2_q;
  logic signed [sset_pkg::DOT_W-1:0]  p_q;

  always_ff @(posedge clk_i) begin
    x2_q <= $unsigned(xx_q) + $unsigned(yy_q) + $unsigned(zz_q);
    v2_q <= $unsigned(vvx_q) + $unsigned(vvy_q) + $unsigned(vvz_q);
    p_q  <= sset_pkg::DOT_W'(xv_q) + sset_pkg::DOT_W'(yv_q) + sset_pkg::DOT_W'(zv_q);
  end

  // stage 3: layer search
  logic [sset_pkg::LAYER_W-1:0] layer_d;
  sset_pkg::status_e            status_d;
  logic [sset_pkg::DOT_W-1:0]   p_abs_d;
  sset_pkg::item_t              it3_q, it4_q, it5_q, it6_q, it7_q;
  logic [SW-1:0]                x2_3_q;
  logic [sset_pkg::RSQ_W-1:0]   r2_q, ri2_q;

  always_comb begin
    layer_d = sset_pkg::LAYER_W'(BOUNDARY_COUNT);
    for (int i = BOUNDARY_COUNT - 1; i >= 0; i--) begin
      if (x2_q < SW'(sset_pkg::RADIUS_SQ[4'(i)])) begin
        layer_d = sset_pkg::LAYER_W'(i);
      end
    end
    if (layer_d == sset_pkg::LAYER_W'(BOUNDARY_COUNT)) begin
      status_d = sset_pkg::STATUS_OUTSIDE;
    end else if (v2_q == '0) begin
      status_d = sset_pkg::STATUS_ZERO_SPEED;
    end else begin
      status_d = sset_pkg::STATUS_OK;
    end
    p_abs_d = p_q[sset_pkg::DOT_W-1] ? $unsigned(-p_q) : $unsigned(p_q);
  end

  always_ff @(posedge clk_i) begin
    it3_q.layer  <= layer_d;
    it3_q.status <= status_d;
    it3_q.pneg   <= p_q[sset_pkg::DOT_W-1];
    it3_q.ap     <= p_abs_d[SW-1:0];
    it3_q.v2     <= v2_q;
    x2_3_q       <= x2_q;
    r2_q         <= sset_pkg::RADIUS_SQ[layer_d[3:0]];
    ri2_q        <= sset_pkg::RADIUS_SQ[layer_d[3:0] - 4'd1];
  end

  // stage 4: distances to the boundaries, margin squared
  logic [SW-1:0]                    dout_w, din_w;
  logic [sset_pkg::RSQ_W-1:0]       dout_q, din_q;
  logic [sset_pkg::MARGIN_SQ_W-1:0] m2_q;

  assign dout_w = SW'(r2_q) - x2_3_q;
  assign din_w  = x2_3_q - SW'(ri2_q);

  always_ff @(posedge clk_i) begin
    dout_q <= dout_w[sset_pkg::RSQ_W-1:0];
    din_q  <= din_w[sset_pkg::RSQ_W-1:0];
    m2_q   <= sset_pkg::MARGIN_SQ_W'(margin_q) * sset_pkg::MARGIN_SQ_W'(margin_q);
    it4_q  <= it3_q;
  end

  // stage 5: partial products on 31-bit limbs
  logic [PW-1:0] aa00_q, aa01_q, aa11_q;
  logic [PW-1:0] do00_q, do01_q, do10_q, do11_q;
  logic [PW-1:0] di00_q, di01_q, di10_q, di11_q;
  logic [sset_pkg::MV_PROD_W-1:0] mv0_q, mv1_q;

  always_ff @(posedge clk_i) begin
    aa00_q <= PW'(it4_q.ap[LW-1:0]) * PW'(it4_q.ap[LW-1:0]);
    aa01_q <= PW'(it4_q.ap[LW-1:0]) * PW'(it4_q.ap[SW-1:LW]);
    aa11_q <= PW'(it4_q.ap[SW-1:LW]) * PW'(it4_q.ap[SW-1:LW]);
    do00_q <= PW'(dout_q[LW-1:0]) * PW'(it4_q.v2[LW-1:0]);
    do01_q <= PW'(dout_q[LW-1:0]) * PW'(it4_q.v2[SW-1:LW]);
    do10_q <= PW'(dout_q[sset_pkg::RSQ_W-1:LW]) * PW'(it4_q.v2[LW-1:0]);
    do11_q <= PW'(dout_q[sset_pkg::RSQ_W-1:LW]) * PW'(it4_q.v2[SW-1:LW]);
    di00_q <= PW'(din_q[LW-1:0]) * PW'(it4_q.v2[LW-1:0]);
    di01_q <= PW'(din_q[LW-1:0]) * PW'(it4_q.v2[SW-1:LW]);
    di10_q <= PW'(din_q[sset_pkg::RSQ_W-1:LW]) * PW'(it4_q.v2[LW-1:0]);
    di11_q <= PW'(din_q[sset_pkg::RSQ_W-1:LW]) * PW'(it4_q.v2[SW-1:LW]);
    mv0_q  <= sset_pkg::MV_PROD_W'(m2_q) * sset_pkg::MV_PROD_W'(it4_q.v2[LW-1:0]);
    mv1_q  <= sset_pkg::MV_PROD_W'(m2_q) * sset_pkg::MV_PROD_W'(it4_q.v2[SW-1:LW]);
    it5_q  <= it4_q;
  end

  // stage 6: full products
  logic [sset_pkg::PP_W-1:0] pp_q;
  logic [sset_pkg::QV_W-1:0] qo_q, qi_q;
  logic [sset_pkg::MV_W-1:0] mv_q;

  always_ff @(posedge clk_i) begin
    pp_q <= (sset_pkg::PP_W'(aa11_q) << 62) + (sset_pkg::PP_W'(aa01_q) << 32)
          + sset_pkg::PP_W'(aa00_q);
    qo_q <= (sset_pkg::QV_W'(do11_q) << 62) + (sset_pkg::QV_W'(do01_q) << 31)
          + (sset_pkg::QV_W'(do10_q) << 31) + sset_pkg::QV_W'(do00_q);
    qi_q <= (sset_pkg::QV_W'(di11_q) << 62) + (sset_pkg::QV_W'(di01_q) << 31)
          + (sset_pkg::QV_W'(di10_q) << 31) + sset_pkg::QV_W'(di00_q);
    mv_q <= (sset_pkg::MV_W'(mv1_q) << 31) + sset_pkg::MV_W'(mv0_q);
    it6_q <= it5_q;
  end

  // stage 7: inner or outer exit, radicand select
  logic                       inner_d;
  logic                       inner_q;
  logic [sset_pkg::RAD_W-1:0] rad_q, mrad_q;

  assign inner_d = (it6_q.layer != '0) && it6_q.pneg
                && (sset_pkg::PP_W'(qi_q) < pp_q);

  always_ff @(posedge clk_i) begin
    rad_q   <= inner_d ? sset_pkg::RAD_W'(pp_q) - sset_pkg::RAD_W'(qi_q)
                       : sset_pkg::RAD_W'(pp_q) + sset_pkg::RAD_W'(qo_q);
    mrad_q  <= sset_pkg::RAD_W'(mv_q);
    inner_q <= inner_d;
    it7_q   <= it6_q;
  end

  // root pipelines
  logic [sset_pkg::ROOT_W-1:0] root_w, mroot_w;
  sset_pkg::item_t             it_r;
  logic                        inner_r;

  sset_isqrt #(
    .RAD_W  (sset_pkg::RAD_W),
    .SIDE_W ($bits(sset_pkg::item_t))
  ) u_root (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s7_v_q),
    .radicand_i (rad_q),
    .side_i     (it7_q),
    .valid_o    (root_v),
    .root_o     (root_w),
    .side_o     (it_r)
  );

  sset_isqrt #(
    .RAD_W  (sset_pkg::RAD_W),
    .SIDE_W (1)
  ) u_margin (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s7_v_q),
    .radicand_i (mrad_q),
    .side_i     (inner_q),
    .valid_o    (margin_v),
    .root_o     (mroot_w),
    .side_o     (inner_r)
  );

  // stage 8 and 9: path length numerator
  logic [sset_pkg::N_W-1:0]    ap_w, s_w, n0_q, n_q;
  logic [sset_pkg::ROOT_W-1:0] sm8_q;
  sset_pkg::item_t             it8_q, it9_q, it10_q, it11_q, it12_q;
  logic                        inner8_q, inner9_q, inner10_q, inner11_q, inner12_q;

  assign ap_w = sset_pkg::N_W'(it_r.ap);
  assign s_w  = sset_pkg::N_W'(root_w);

  always_ff @(posedge clk_i) begin
    if (inner_r) begin
      n0_q <= ap_w - s_w;
    end else if (it_r.pneg) begin
      n0_q <= s_w + ap_w;
    end else begin
      n0_q <= s_w - ap_w;
    end
    sm8_q    <= mroot_w;
    it8_q    <= it_r;
    inner8_q <= inner_r;
    n_q      <= n0_q + sset_pkg::N_W'(sm8_q);
    it9_q    <= it8_q;
    inner9_q <= inner8_q;
  end

  // stage 10 to 12: scale to ns, overflow check
  logic [PW-1:0] pr0_q, pr1_q;
  logic [NW-1:0] num_q, num12_q;
  logic          sat12_q;

  always_ff @(posedge clk_i) begin
    pr1_q     <= PW'(n_q[63:32]) * PW'(sset_pkg::NS_PER_S);
    pr0_q     <= PW'(n_q[31:0]) * PW'(sset_pkg::NS_PER_S);
    it10_q    <= it9_q;
    inner10_q <= inner9_q;
    num_q     <= (NW'(pr1_q) << 32) + NW'(pr0_q);
    it11_q    <= it10_q;
    inner11_q <= inner10_q;
    sat12_q   <= DW'(num_q) >= (DW'(it11_q.v2) << TW);
    num12_q   <= num_q;
    it12_q    <= it11_q;
    inner12_q <= inner11_q;
  end

  // restoring divider, one quotient bit per stage
  logic [NW-1:0]   drem_q  [TW];
  logic [TW-1:0]   dquo_q  [TW];
  sset_pkg::item_t dit_q   [TW];
  logic [TW-1:0]   dinner_q, dsat_q;

  for (genvar j = 0; j < TW; j++) begin : g_div
    localparam int unsigned B = TW - 1 - j;
    logic            v_c, inner_c, sat_c, ge;
    logic [NW-1:0]   rem_c;
    logic [TW-1:0]   quo_c;
    sset_pkg::item_t it_c;
    logic [DW-1:0]   dsor;

    if (j == 0) begin : g_first
      assign v_c     = s12_v_q;
      assign rem_c   = num12_q;
      assign quo_c   = '0;
      assign it_c    = it12_q;
      assign inner_c = inner12_q;
      assign sat_c   = sat12_q;
    end else begin : g_next
      assign v_c     = dv_q[j-1];
      assign rem_c   = drem_q[j-1];
      assign quo_c   = dquo_q[j-1];
      assign it_c    = dit_q[j-1];
      assign inner_c = dinner_q[j-1];
      assign sat_c   = dsat_q[j-1];
    end

    assign dsor = DW'(it_c.v2) << B;
    assign ge   = DW'(rem_c) >= dsor;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j] <= 1'b0;
      end else begin
        dv_q[j] <= v_c;
      end
    end

    always_ff @(posedge clk_i) begin
      drem_q[j]   <= ge ? rem_c - dsor[NW-1:0] : rem_c;
      dquo_q[j]   <= quo_c | (ge ? (TW'(1) << B) : '0);
      dit_q[j]    <= it_c;
      dinner_q[j] <= inner_c;
      dsat_q[j]   <= sat_c;
    end
  end

  // output register
  logic [sset_pkg::LAYER_OUT_W-1:0] out_layer_q;
  logic [TW-1:0]                    out_time_q;
  logic                             out_inner_q;
  sset_pkg::status_e                out_status_q;
  sset_pkg::item_t                  it_f;

  assign it_f = dit_q[TW-1];

  always_ff @(posedge clk_i) begin
    out_layer_q  <= it_f.layer[sset_pkg::LAYER_OUT_W-1:0];
    out_status_q <= it_f.status;
    if (it_f.status != sset_pkg::STATUS_OK) begin
      out_time_q  <= '0;
      out_inner_q <= 1'b0;
    end else begin
      out_time_q  <= dsat_q[TW-1] ? '1 : dquo_q[TW-1];
      out_inner_q <= dinner_q[TW-1];
    end
  end

  assign out_strobe_o    = out_v_q;
  assign layer_index_o   = out_layer_q;
  assign exit_time_ns_o  = out_time_q;
  assign through_inner_o = out_inner_q;
  assign status_o        = out_status_q;

endmodule

`default_nettype wire

FILE: sv/sset_checker.sv
// ---------------------------------------------------------------------------
// sset_checker
// port level checks on result items of the shell exit time unit
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "spherical_shell_exit_time_unit_macros.svh"

module sset_checker #(
  parameter int BOUNDARY_COUNT = 10
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_strobe_o,
  input logic [sset_pkg::LAYER_OUT_W-1:0] layer_index_o,
  input logic [sset_pkg::TIME_W-1:0]      exit_time_ns_o,
  input logic                             through_inner_o,
  input logic [sset_pkg::STATUS_W-1:0]    status_o
);

  `SSET_ON_RESULT(a_status_known, status_o == sset_pkg::STATUS_OK || status_o == sset_pkg::STATUS_OUTSIDE || status_o == sset_pkg::STATUS_ZERO_SPEED, "unknown status code")
  `SSET_ON_RESULT(a_fail_clears, status_o == sset_pkg::STATUS_OK || (exit_time_ns_o == '0 && !through_inner_o), "failed item carries a time")
  `SSET_ON_RESULT(a_outside_layer, status_o != sset_pkg::STATUS_OUTSIDE || layer_index_o == 4'(BOUNDARY_COUNT), "outside item with wrong layer")
  `SSET_ON_RESULT(a_inside_layer, status_o == sset_pkg::STATUS_OUTSIDE || 32'(layer_index_o) < BOUNDARY_COUNT, "inside item with layer out of range")

endmodule

bind spherical_shell_exit_time_unit sset_checker #(
  .BOUNDARY_COUNT (BOUNDARY_COUNT)
) u_sset_checker (.*);

`default_nettype wire

FILE: sim/sset_checker.sv
// ---------------------------------------------------------------------------
// sset_tb_checker
// watches the item, config and result ports of the shell exit time unit,
// predicts each result from the accepted items and compares it field by field
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sset_tb_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  input  logic                                busy,
  input  logic signed [sset_pkg::COORD_W-1:0] pos_x_i,
  input  logic signed [sset_pkg::COORD_W-1:0] pos_y_i,
  input  logic signed [sset_pkg::COORD_W-1:0] pos_z_i,
  input  logic signed [sset_pkg::COORD_W-1:0] vel_x_i,
  input  logic signed [sset_pkg::COORD_W-1:0] vel_y_i,
  input  logic signed [sset_pkg::COORD_W-1:0] vel_z_i,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_o,
  input  logic [sset_pkg::MARGIN_W-1:0]       cfg_data_i,
  input  logic                                out_strobe_o,
  input  logic [sset_pkg::LAYER_OUT_W-1:0]    layer_index_o,
  input  logic [sset_pkg::TIME_W-1:0]         exit_time_ns_o,
  input  logic                                through_inner_o,
  input  logic [sset_pkg::STATUS_W-1:0]       status_o,
  output int                                  fail_count_o,
  output int                                  pending_o
);

  localparam int SHELLS = 10;

  typedef struct {
    logic [sset_pkg::LAYER_OUT_W-1:0] layer;
    logic [sset_pkg::TIME_W-1:0]      t_ns;
    logic                             inner;
    sset_pkg::status_e                status;
  } exit_result_t;

  logic [sset_pkg::MARGIN_W-1:0] margin_cm;
  exit_result_t                  exit_q[$];

  function automatic logic [63:0] floor_root(logic [127:0] n);
    logic [63:0]  r;
    logic [63:0]  t;
    logic [127:0] tt;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      tt = 128'(t) * 128'(t);
      if (!(n < tt)) r = t;
    end
    return r;
  endfunction

  function automatic exit_result_t predict_exit(
    logic signed [sset_pkg::COORD_W-1:0] px, logic signed [sset_pkg::COORD_W-1:0] py,
    logic signed [sset_pkg::COORD_W-1:0] pz, logic signed [sset_pkg::COORD_W-1:0] vx,
    logic signed [sset_pkg::COORD_W-1:0] vy, logic signed [sset_pkg::COORD_W-1:0] vz,
    logic [sset_pkg::MARGIN_W-1:0] m);
    longint       sx, sy, sz, wx, wy, wz, p;
    logic [63:0]  x2, v2, ap, nval, r2, ri2;
    logic [127:0] pp, q, num, v2w, mw;
    int           lay;
    exit_result_t r;
    sx = px; sy = py; sz = pz; wx = vx; wy = vy; wz = vz;
    x2 = 64'(sx * sx + sy * sy + sz * sz);
    v2 = 64'(wx * wx + wy * wy + wz * wz);
    p  = sx * wx + sy * wy + sz * wz;
    ap = (p < 0) ? 64'(-p) : 64'(p);
    lay = SHELLS;
    for (int i = SHELLS - 1; i >= 0; i--)
      if (x2 < 64'(sset_pkg::RADIUS_SQ[i])) lay = i;
    r.layer = 4'(lay);
    r.t_ns = '0;
    r.inner = 1'b0;
    r.status = sset_pkg::STATUS_OK;
    if (lay >= SHELLS) begin
      r.status = sset_pkg::STATUS_OUTSIDE;
    end else if (v2 == 0) begin
      r.status = sset_pkg::STATUS_ZERO_SPEED;
    end else begin
      v2w = 128'(v2);
      pp = 128'(ap) * 128'(ap);
      r2 = 64'(sset_pkg::RADIUS_SQ[lay]);
      nval = floor_root(pp + 128'(r2 - x2) * v2w) - 64'(p);
      if (lay > 0 && p < 0) begin
        ri2 = 64'(sset_pkg::RADIUS_SQ[lay-1]);
        q = 128'(x2 - ri2) * v2w;
        if (q < pp) begin
          nval = ap - floor_root(pp - q);
          r.inner = 1'b1;
        end
      end
      mw = 128'(m);
      nval = nval + floor_root(mw * mw * v2w);
      num = 128'(nval) * 128'd1000000000;
      if (!(num < (v2w << 48))) r.t_ns = {sset_pkg::TIME_W{1'b1}};
      else r.t_ns = sset_pkg::TIME_W'(num / v2w);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    exit_result_t e;
    if (!rst_ni) begin
      margin_cm <= 10'd1;
      exit_q.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) margin_cm <= cfg_data_i;
      if (out_strobe_o) begin
        if (exit_q.size() == 0) begin
          $error("result item with no item pending");
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = exit_q.pop_front();
          if (layer_index_o !== e.layer || exit_time_ns_o !== e.t_ns ||
              through_inner_o !== e.inner || status_o !== e.status)
            fail_count_o <= fail_count_o + 1;
          if (layer_index_o !== e.layer)
            $error("layer_index expected %0d got %0d", e.layer, layer_index_o);
          if (exit_time_ns_o !== e.t_ns)
            $error("exit_time_ns expected %0d got %0d", e.t_ns, exit_time_ns_o);
          if (through_inner_o !== e.inner)
            $error("through_inner expected %0d got %0d", e.inner, through_inner_o);
          if (status_o !== e.status)
            $error("status expected %0d got %0d", e.status, status_o);
        end
      end
      if (start && !busy)
        exit_q.insert(exit_q.size(), predict_exit(pos_x_i, pos_y_i, pos_z_i,
                                                  vel_x_i, vel_y_i, vel_z_i, margin_cm));
      pending_o <= exit_q.size();
    end
  end

endmodule

FILE: sim/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// drives directed and random trajectories and margin writes into the shell
// exit time unit, with random idle bursts, and reports the verdict
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int RANDOM_ITEMS = 1700;
  localparam int QUIET_FROM   = 1500;
  localparam int IDLE_LIMIT   = 5000;
  localparam int LATENCY      = 124;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [sset_pkg::COORD_W-1:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic signed [sset_pkg::COORD_W-1:0] vel_x_i = '0, vel_y_i = '0, vel_z_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [sset_pkg::MARGIN_W-1:0] cfg_data_i = '0;
  logic out_strobe_o;
  logic [sset_pkg::LAYER_OUT_W-1:0] layer_index_o;
  logic [sset_pkg::TIME_W-1:0] exit_time_ns_o;
  logic through_inner_o;
  logic [sset_pkg::STATUS_W-1:0] status_o;
  int fail_count, pending, idle_cycles;

  int radius_cm[10] = '{122150000, 348000000, 570100000, 577100000, 597100000,
                        615100000, 634660000, 635600000, 636800000, 637100000};

  always #10 clk_i = ~clk_i;

  spherical_shell_exit_time_unit dut (.*);

  sset_tb_checker u_checker (.*, .fail_count_o(fail_count), .pending_o(pending));

  always @(posedge clk_i) begin
    if ((start && !busy) || (cfg_valid_i && cfg_ready_o) || out_strobe_o)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // random value within +-2^k
  function automatic logic signed [sset_pkg::COORD_W-1:0] rand_coord(int k);
    logic signed [sset_pkg::COORD_W-1:0] v;
    v = sset_pkg::COORD_W'($urandom);
    return v >>> (30 - k);
  endfunction

  task automatic send_item(int px, int py, int pz, int vx, int vy, int vz);
    start <= 1'b1;
    pos_x_i <= sset_pkg::COORD_W'(px);
    pos_y_i <= sset_pkg::COORD_W'(py);
    pos_z_i <= sset_pkg::COORD_W'(pz);
    vel_x_i <= sset_pkg::COORD_W'(vx);
    vel_y_i <= sset_pkg::COORD_W'(vy);
    vel_z_i <= sset_pkg::COORD_W'(vz);
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_margin(logic [sset_pkg::MARGIN_W-1:0] m);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= m;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random;
    logic signed [sset_pkg::COORD_W-1:0] p[3], v[3];
    int mode, ax;
    mode = $urandom_range(0, 9);
    for (int a = 0; a < 3; a++) begin
      p[a] = rand_coord(mode == 0 ? 30 : $urandom_range(0, 28));
      v[a] = rand_coord(mode == 1 ? 30 : $urandom_range(0, 30));
    end
    if (mode >= 5) begin
      // near a boundary along one axis
      ax = $urandom_range(0, 2);
      p[ax] = radius_cm[$urandom_range(0, 9)] + rand_coord($urandom_range(0, 12));
      if ($urandom_range(0, 1)) p[ax] = -p[ax];
      p[(ax + 1) % 3] = rand_coord($urandom_range(0, 20));
      p[(ax + 2) % 3] = rand_coord($urandom_range(0, 20));
      if ($urandom_range(0, 1)) v[ax] = (p[ax] > 0) ? -v[ax] : v[ax];
    end
    if ($urandom_range(0, 40) == 0) v = '{0, 0, 0};
    send_item(p[0], p[1], p[2], v[0], v[1], v[2]);
  endtask

  initial begin
    idle_cycles = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_margin(10'd1000);
    // zero speed, still at the center, then the far corners of the field range
    send_item(0, 0, 0, 0, 0, 0);
    send_item(1073741823, 1073741823, 1073741823, 1073741823, 1073741823, 1073741823);
    send_item(-1073741824, -1073741824, -1073741824, -1073741824, -1073741824,
              -1073741824);
    send_item(-1073741824, 0, 0, 0, 0, 0);
    send_item(0, 0, 0, 1073741823, -1073741824, 1073741823);
    send_item(0, 0, 0, 1, 0, 0);
    // on a boundary, just inside, outermost edge
    send_item(348000000, 0, 0, 5, 0, 0);
    send_item(347999999, 0, 0, -5, 0, 0);
    send_item(0, 0, 637099999, 0, 0, 1000);
    send_item(0, 0, 637100000, 0, 0, 1000);
    // inner exit head on, grazing miss of the inner boundary, tangent path
    send_item(200000000, 0, 0, -30000, 0, 0);
    send_item(200000000, 122150000, 0, -30000, 0, 0);
    send_item(200000000, 0, 0, 0, 1073741823, 0);
    send_item(600000000, 0, 0, -1, 0, 0);
    send_item(-400000000, 300000000, 100000000, 12345, -6789, 1000);
    write_margin(10'd0);
    send_item(1000, 0, 0, 1073741823, 1073741823, 1073741823);
    send_item(0, 0, 0, -1073741824, -1073741824, -1073741824);
    write_margin(10'd1023);
    send_item(0, 0, 0, 1, 1, 1);
    send_item(500000000, -100, 7, -1073741824, 3, 0);
    drain();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 400) write_margin(10'd0);
      if (i == 600) drain();
      if (i == 800) write_margin(10'd1023);
      if (i == 1200) write_margin(sset_pkg::MARGIN_W'($urandom_range(0, 1023)));
      if (i == 1400) write_margin(10'd1);
      send_random();
      if (i < QUIET_FROM && $urandom_range(0, 5) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
    end
    drain();
    repeat (LATENCY + 8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
